[sv/tpc_pkg.sv]
// Package for the triangle plane classifier: vertex side codes, group codes,
// register indexes, fixed field widths and the stage enable bundle.
// No dependencies; every other file of the block uses it.
package tpc_pkg;

	localparam int TOL_WIDTH     = 40;
	localparam int IDX_WIDTH     = 32;
	localparam int CODE_WIDTH    = 3;
	localparam int CFG_IDX_WIDTH = 3;

	typedef logic [1:0] side_t;
	localparam side_t SIDE_ON  = 2'd0;
	localparam side_t SIDE_POS = 2'd1;
	localparam side_t SIDE_NEG = 2'd2;

	typedef logic [CODE_WIDTH-1:0] group_t;
	localparam group_t GRP_ALL_POS  = 3'd0;
	localparam group_t GRP_ALL_NEG  = 3'd1;
	localparam group_t GRP_ALL_ON   = 3'd2;
	localparam group_t GRP_2POS_1ON = 3'd3;
	localparam group_t GRP_1POS_2ON = 3'd4;
	localparam group_t GRP_2NEG_1ON = 3'd5;
	localparam group_t GRP_1NEG_2ON = 3'd6;
	localparam group_t GRP_CROSSING = 3'd7;

	typedef logic [CFG_IDX_WIDTH-1:0] reg_idx_t;
	localparam reg_idx_t REG_POINT_X  = 3'd0;
	localparam reg_idx_t REG_POINT_Y  = 3'd1;
	localparam reg_idx_t REG_POINT_Z  = 3'd2;
	localparam reg_idx_t REG_NORMAL_X = 3'd3;
	localparam reg_idx_t REG_NORMAL_Y = 3'd4;
	localparam reg_idx_t REG_NORMAL_Z = 3'd5;
	localparam reg_idx_t REG_TOL      = 3'd6;

	localparam logic [TOL_WIDTH-1:0] TOL_RESET = 40'd4;

	// Load enables of the four lane stages.
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
	} stage_en_t;

endpackage

[sv/triangle_plane_classifier.sv]
// Triangle plane classifier: marks each vertex of a triangle as above, below
// or on a configured plane and reports the triangle's group code.
//
// Input stream s_*: one triangle per transfer, nine coordinates and the index.
// Output stream m_*: group code and the index, one result per triangle.
// Configuration port cfg_*: register index and data, always ready; write only
// while no triangle is in flight.
// Three vertex lanes run side by side, four register stages each (difference,
// products, sum, tolerance test), then the merge stage is the output register.
// An accepted triangle passes the lane stages and the merge register to
// m_tvalid; a new triangle can be accepted every cycle unless the receiver
// stalls a full pipeline. The rate is set by the per-stage handshake: each
// stage loads when it is empty or when the stage after it moves, so bubbles
// close up while the receiver stalls and input is still taken until every
// stage holds a triangle. With m_tready held high, s_tready stays high.
// Reset empties all stages and sets point 0, normal (0,0,65536), tolerance 4.
module triangle_plane_classifier #(
	parameter int COORD_WIDTH = 32
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       s_tvalid,
	output logic                                       s_tready,
	// v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z, triangle_index
	input  logic [((9*COORD_WIDTH+tpc_pkg::IDX_WIDTH+7)/8)*8-1:0] s_tdata,
	output logic                                       m_tvalid,
	input  logic                                       m_tready,
	// group_code, tri_index_out, zero fill
	output logic [((tpc_pkg::CODE_WIDTH+tpc_pkg::IDX_WIDTH+7)/8)*8-1:0] m_tdata,
	input  logic                                       cfg_valid,
	output logic                                       cfg_ready,
	input  logic [tpc_pkg::CFG_IDX_WIDTH-1:0]          cfg_index,
	input  logic [((COORD_WIDTH > tpc_pkg::TOL_WIDTH) ? COORD_WIDTH : tpc_pkg::TOL_WIDTH)-1:0] cfg_data
);
	localparam int CW     = COORD_WIDTH;
	localparam int IW     = tpc_pkg::IDX_WIDTH;
	localparam int OUT_W  = ((tpc_pkg::CODE_WIDTH + IW + 7) / 8) * 8;
	localparam logic [CW-1:0] NZ_RESET = CW'(65536);

	logic [CW-1:0] point_q [3];
	logic [CW-1:0] normal_q [3];
	logic [tpc_pkg::TOL_WIDTH-1:0] tol_q;

	logic v_s1, v_s2, v_s3, v_s4, out_vld_q;
	logic en5;
	tpc_pkg::stage_en_t en;
	logic [IW-1:0] idx_s1, idx_s2, idx_s3, idx_s4;

	tpc_pkg::side_t  side [3];
	tpc_pkg::group_t code;
	logic [IW-1:0]   idx_out;

	// Configuration registers.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_q[0]  <= '0;
			point_q[1]  <= '0;
			point_q[2]  <= '0;
			normal_q[0] <= '0;
			normal_q[1] <= '0;
			normal_q[2] <= NZ_RESET;
			tol_q       <= tpc_pkg::TOL_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				tpc_pkg::REG_POINT_X:  point_q[0]  <= cfg_data[CW-1:0];
				tpc_pkg::REG_POINT_Y:  point_q[1]  <= cfg_data[CW-1:0];
				tpc_pkg::REG_POINT_Z:  point_q[2]  <= cfg_data[CW-1:0];
				tpc_pkg::REG_NORMAL_X: normal_q[0] <= cfg_data[CW-1:0];
				tpc_pkg::REG_NORMAL_Y: normal_q[1] <= cfg_data[CW-1:0];
				tpc_pkg::REG_NORMAL_Z: normal_q[2] <= cfg_data[CW-1:0];
				tpc_pkg::REG_TOL:      tol_q       <= cfg_data[tpc_pkg::TOL_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	// Stage enables: a stage loads when empty or when its successor loads.
	always_comb begin
		en5   = !out_vld_q || m_tready;
		en.s4 = !v_s4 || en5;
		en.s3 = !v_s3 || en.s4;
		en.s2 = !v_s2 || en.s3;
		en.s1 = !v_s1 || en.s2;
	end

	assign s_tready = en.s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			v_s4      <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (en.s1) v_s1 <= s_tvalid;
			if (en.s2) v_s2 <= v_s1;
			if (en.s3) v_s3 <= v_s2;
			if (en.s4) v_s4 <= v_s3;
			if (en5)   out_vld_q <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en.s1) idx_s1 <= s_tdata[9*CW +: IW];
		if (en.s2) idx_s2 <= idx_s1;
		if (en.s3) idx_s3 <= idx_s2;
		if (en.s4) idx_s4 <= idx_s3;
	end

	for (genvar g = 0; g < 3; g++) begin : g_lane
		tpc_lane #(
			.COORD_WIDTH(CW)
		) u_lane (
			.clk  (clk),
			.en   (en),
			.vx   (s_tdata[(3*g+0)*CW +: CW]),
			.vy   (s_tdata[(3*g+1)*CW +: CW]),
			.vz   (s_tdata[(3*g+2)*CW +: CW]),
			.px   (point_q[0]),
			.py   (point_q[1]),
			.pz   (point_q[2]),
			.nx   (normal_q[0]),
			.ny   (normal_q[1]),
			.nz   (normal_q[2]),
			.tol  (tol_q),
			.side (side[g])
		);
	end

	tpc_merge u_merge (
		.clk     (clk),
		.load    (en5 && v_s4),
		.side0   (side[0]),
		.side1   (side[1]),
		.side2   (side[2]),
		.idx_in  (idx_s4),
		.code    (code),
		.idx_out (idx_out)
	);

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {{(OUT_W - tpc_pkg::CODE_WIDTH - IW){1'b0}}, idx_out, code};

endmodule

[sv/tpc_lane.sv]
// One vertex lane: difference to the plane point, products with the normal,
// exact sum and the tolerance test, one register stage each.
// Depends on tpc_pkg.
module tpc_lane #(
	parameter int COORD_WIDTH = 32
) (
	input  logic                            clk,
	input  tpc_pkg::stage_en_t              en,
	input  logic [COORD_WIDTH-1:0]          vx,
	input  logic [COORD_WIDTH-1:0]          vy,
	input  logic [COORD_WIDTH-1:0]          vz,
	input  logic [COORD_WIDTH-1:0]          px,
	input  logic [COORD_WIDTH-1:0]          py,
	input  logic [COORD_WIDTH-1:0]          pz,
	input  logic [COORD_WIDTH-1:0]          nx,
	input  logic [COORD_WIDTH-1:0]          ny,
	input  logic [COORD_WIDTH-1:0]          nz,
	input  logic [tpc_pkg::TOL_WIDTH-1:0]   tol,
	output tpc_pkg::side_t                  side
);
	localparam int DW  = COORD_WIDTH + 1;
	localparam int PW  = 2 * COORD_WIDTH + 1;
	localparam int SW  = PW + 2;
	localparam int CMW = ((SW > tpc_pkg::TOL_WIDTH + 1) ? SW : tpc_pkg::TOL_WIDTH + 1) + 1;

	logic signed [DW-1:0]  dx_s1, dy_s1, dz_s1;
	logic signed [PW-1:0]  mx_s2, my_s2, mz_s2;
	logic signed [SW-1:0]  sum_s3;
	tpc_pkg::side_t        side_s4;

	logic signed [CMW-1:0] sum_c;
	logic signed [CMW-1:0] tol_c;
	logic                  on_c;
	logic                  pos_c;

	always_ff @(posedge clk) begin
		if (en.s1) begin
			dx_s1 <= $signed({vx[COORD_WIDTH-1], vx}) - $signed({px[COORD_WIDTH-1], px});
			dy_s1 <= $signed({vy[COORD_WIDTH-1], vy}) - $signed({py[COORD_WIDTH-1], py});
			dz_s1 <= $signed({vz[COORD_WIDTH-1], vz}) - $signed({pz[COORD_WIDTH-1], pz});
		end
		if (en.s2) begin
			mx_s2 <= dx_s1 * $signed(nx);
			my_s2 <= dy_s1 * $signed(ny);
			mz_s2 <= dz_s1 * $signed(nz);
		end
		if (en.s3) begin
			sum_s3 <= $signed({{2{mx_s2[PW-1]}}, mx_s2})
				+ $signed({{2{my_s2[PW-1]}}, my_s2})
				+ $signed({{2{mz_s2[PW-1]}}, mz_s2});
		end
		if (en.s4) begin
			side_s4 <= on_c ? tpc_pkg::SIDE_ON : (pos_c ? tpc_pkg::SIDE_POS : tpc_pkg::SIDE_NEG);
		end
	end

	// |d| < tol is tested as -tol < d < tol; with zero tolerance nothing is on-plane.
	always_comb begin
		sum_c = $signed({{(CMW-SW){sum_s3[SW-1]}}, sum_s3});
		tol_c = $signed({{(CMW-tpc_pkg::TOL_WIDTH){1'b0}}, tol});
		on_c  = (sum_c < tol_c) && (sum_c > -tol_c);
		pos_c = (sum_c > $signed({CMW{1'b0}}));
	end

	assign side = side_s4;

endmodule

[sv/tpc_merge.sv]
// Merge stage: counts the three vertex sides, picks the group code and holds
// the result with the triangle index in the output register.
// Depends on tpc_pkg.
module tpc_merge (
	input  logic                            clk,
	input  logic                            load,
	input  tpc_pkg::side_t                  side0,
	input  tpc_pkg::side_t                  side1,
	input  tpc_pkg::side_t                  side2,
	input  logic [tpc_pkg::IDX_WIDTH-1:0]   idx_in,
	output tpc_pkg::group_t                 code,
	output logic [tpc_pkg::IDX_WIDTH-1:0]   idx_out
);
	logic [1:0]       n_on, n_pos, n_neg;
	tpc_pkg::group_t  code_c;
	tpc_pkg::group_t  code_q;
	logic [tpc_pkg::IDX_WIDTH-1:0] idx_q;

	always_comb begin
		n_on  = 2'({1'b0, side0 == tpc_pkg::SIDE_ON}) + 2'({1'b0, side1 == tpc_pkg::SIDE_ON})
			+ 2'({1'b0, side2 == tpc_pkg::SIDE_ON});
		n_pos = 2'({1'b0, side0 == tpc_pkg::SIDE_POS}) + 2'({1'b0, side1 == tpc_pkg::SIDE_POS})
			+ 2'({1'b0, side2 == tpc_pkg::SIDE_POS});
		n_neg = 2'({1'b0, side0 == tpc_pkg::SIDE_NEG}) + 2'({1'b0, side1 == tpc_pkg::SIDE_NEG})
			+ 2'({1'b0, side2 == tpc_pkg::SIDE_NEG});
		if (n_pos == 2'd3) begin
			code_c = tpc_pkg::GRP_ALL_POS;
		end else if (n_neg == 2'd3) begin
			code_c = tpc_pkg::GRP_ALL_NEG;
		end else if (n_on == 2'd3) begin
			code_c = tpc_pkg::GRP_ALL_ON;
		end else if (n_pos == 2'd2 && n_on == 2'd1) begin
			code_c = tpc_pkg::GRP_2POS_1ON;
		end else if (n_pos == 2'd1 && n_on == 2'd2) begin
			code_c = tpc_pkg::GRP_1POS_2ON;
		end else if (n_neg == 2'd2 && n_on == 2'd1) begin
			code_c = tpc_pkg::GRP_2NEG_1ON;
		end else if (n_neg == 2'd1 && n_on == 2'd2) begin
			code_c = tpc_pkg::GRP_1NEG_2ON;
		end else begin
			code_c = tpc_pkg::GRP_CROSSING;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			code_q <= code_c;
			idx_q  <= idx_in;
		end
	end

	assign code    = code_q;
	assign idx_out = idx_q;

endmodule

[sv/tpc_checker.sv]
// Port-level checks for the triangle plane classifier, attached by bind.
// Depends on tpc_pkg and the top level's port list.
module tpc_checker #(
	parameter int COORD_WIDTH = 32
) (
	input logic clk,
	input logic arst_n,
	input logic s_tready,
	input logic m_tvalid,
	input logic m_tready,
	input logic [((tpc_pkg::CODE_WIDTH+tpc_pkg::IDX_WIDTH+7)/8)*8-1:0] m_tdata
);
	// A result that is not taken stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result withdrawn before transfer");

	// A stalled result keeps its payload.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("result changed while stalled");

	// A receiver that takes every result never holds back the sender.
	a_no_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		m_tready |-> s_tready)
		else $error("input stalled while output is ready");

	// With the output register empty the whole pipeline can advance.
	a_empty_out_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output register");

endmodule

bind triangle_plane_classifier tpc_checker #(
	.COORD_WIDTH(COORD_WIDTH)
) u_tpc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
